[src/pmst_pkg.sv]
// Shared types and constants for the Prim spanning tree block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pmst_pkg;

    // fixed field widths of the item streams
    localparam int VERT_BITS     = 3;
    localparam int WEIGHT_IN_BITS = 8;
    localparam int TOTAL_BITS    = 14;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // item operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_RUN    = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    // command from the input side to the matrix store
    typedef struct packed {
        logic                      valid;
        opcode_t                   op;
        logic [VERT_BITS-1:0]      vertex_a;
        logic [VERT_BITS-1:0]      vertex_b;
        logic [WEIGHT_IN_BITS-1:0] weight;
    } mat_cmd_t;

    // one result item
    typedef struct packed {
        logic [VERT_BITS-1:0]      parent_vertex;
        logic [VERT_BITS-1:0]      child_vertex;
        logic [WEIGHT_IN_BITS-1:0] edge_weight;
        logic [TOTAL_BITS-1:0]     total_weight;
        logic                      last;
        logic                      disconnected;
    } result_t;

endpackage

[src/pmst_matrix.sv]
// Adjacency cost matrix store: one synchronous memory, one entry per vertex pair.
// Handles edge inserts (two mirrored writes) and clearing sweeps; depends on pmst_pkg.
`timescale 1ns / 1ps

module pmst_matrix
    import pmst_pkg::*;
#(
    parameter int VERTICES    = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mat_cmd_t                        cmd_i,
    output logic                            busy_o,
    input  logic                            rd_en_i,
    input  logic [$clog2(VERTICES)-1:0]     rd_row_i,
    input  logic [$clog2(VERTICES)-1:0]     rd_col_i,
    output logic [WEIGHT_BITS-1:0]          rd_data_o
);

    localparam int VW = $clog2(VERTICES);
    localparam int AW = $clog2(VERTICES * VERTICES);
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE  = '1;
    localparam logic [AW-1:0]          LAST_ADDR = AW'(VERTICES * VERTICES - 1);

    typedef enum logic [1:0] {
        M_CLEAR,
        M_IDLE,
        M_MIRROR
    } mstate_t;

    mstate_t                state_reg;
    logic [AW-1:0]          ptr_reg;
    logic [VW-1:0]          row_reg;
    logic [VW-1:0]          col_reg;
    logic [WEIGHT_BITS-1:0] w_reg;

    logic [WEIGHT_BITS-1:0] mem [VERTICES * VERTICES];
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic                   ins_ok;

    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] r, input logic [VW-1:0] c);
        return AW'(r) * AW'(VERTICES) + AW'(c);
    endfunction

    // insert is taken only with both endpoints inside the graph
    assign ins_ok = cmd_i.valid && (cmd_i.op == OP_INSERT)
                    && (32'(cmd_i.vertex_a) < VERTICES) && (32'(cmd_i.vertex_b) < VERTICES);

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = NO_EDGE;
        case (state_reg)
            M_CLEAR: begin
                wr_en = 1'b1;
            end
            M_MIRROR: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(col_reg, row_reg);
                wr_data = w_reg;
            end
            M_IDLE: begin
                if (ins_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = addr_of(VW'(cmd_i.vertex_a), VW'(cmd_i.vertex_b));
                    wr_data = WEIGHT_BITS'(cmd_i.weight);
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // sequencer for clearing sweeps and mirrored writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_CLEAR;
            ptr_reg   <= '0;
        end else begin
            case (state_reg)
                M_CLEAR: begin
                    if (ptr_reg == LAST_ADDR) begin
                        state_reg <= M_IDLE;
                    end
                    ptr_reg <= ptr_reg + 1'b1;
                end
                M_IDLE: begin
                    if (ins_ok) begin
                        state_reg <= M_MIRROR;
                        row_reg   <= VW'(cmd_i.vertex_a);
                        col_reg   <= VW'(cmd_i.vertex_b);
                        w_reg     <= WEIGHT_BITS'(cmd_i.weight);
                    end else if (cmd_i.valid && (cmd_i.op == OP_CLEAR)) begin
                        state_reg <= M_CLEAR;
                        ptr_reg   <= '0;
                    end
                end
                M_MIRROR: begin
                    state_reg <= M_IDLE;
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en_i) begin
            rd_data_reg <= mem[addr_of(rd_row_i, rd_col_i)];
        end
    end

    assign rd_data_o = rd_data_reg;
    assign busy_o    = (state_reg != M_IDLE);

endmodule

[src/pmst_engine.sv]
// Prim run sequencer: best-cost/parent memory, tree membership and per-step scan.
// Reads matrix rows through the pmst_matrix read port; depends on pmst_pkg.
`timescale 1ns / 1ps

module pmst_engine
    import pmst_pkg::*;
#(
    parameter int VERTICES    = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start_i,
    input  logic [VERT_BITS-1:0]            start_vertex_i,
    output logic                            busy_o,
    output logic                            mat_rd_en_o,
    output logic [$clog2(VERTICES)-1:0]     mat_rd_row_o,
    output logic [$clog2(VERTICES)-1:0]     mat_rd_col_o,
    input  logic [WEIGHT_BITS-1:0]          mat_rd_data_i,
    output logic                            res_valid_o,
    input  logic                            res_ready_i,
    output result_t                         res_o
);

    localparam int VW = $clog2(VERTICES);
    localparam int SW = ((WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS) + 1;
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;
    localparam logic [VW-1:0]          LAST_V  = VW'(VERTICES - 1);

    typedef enum logic [1:0] {
        E_IDLE,
        E_PASS,
        E_WAIT,
        E_EMIT
    } estate_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] cost;
        logic [VW-1:0]          parent;
    } best_t;

    estate_t                state_reg;
    logic [VW-1:0]          cur_reg;
    logic [VW-1:0]          idx_reg;
    logic [VW-1:0]          step_reg;
    logic                   first_reg;
    logic [VERTICES-1:0]    in_tree_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [WEIGHT_BITS-1:0] min_cost_reg;
    logic [VW-1:0]          min_idx_reg;
    logic [VW-1:0]          min_par_reg;
    logic                   found_reg;
    logic                   s1_vld_reg;
    logic [VW-1:0]          s1_idx_reg;

    best_t                  best_mem [VERTICES];
    best_t                  best_rd_reg;

    logic                   rd_en;
    logic                   s1_open;
    logic                   take;
    best_t                  new_best;
    logic                   wr_en;
    logic                   better;
    logic [SW-1:0]          sum_wide;
    logic [TOTAL_BITS-1:0]  sum_sat;
    logic                   last_step;

    assign rd_en = (state_reg == E_PASS);

    // relax one entry: the first pass seeds every entry outside the tree from the start row
    always_comb begin
        s1_open  = s1_vld_reg && !in_tree_reg[s1_idx_reg];
        take     = first_reg || (mat_rd_data_i < best_rd_reg.cost);
        new_best = best_rd_reg;
        if (take) begin
            new_best.cost   = mat_rd_data_i;
            new_best.parent = cur_reg;
        end
        wr_en  = s1_open && take;
        better = s1_open && (new_best.cost < min_cost_reg);
    end

    // saturating running total with the chosen edge
    always_comb begin
        sum_wide = SW'(total_reg) + SW'(min_cost_reg);
        sum_sat  = (sum_wide > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(sum_wide);
    end

    assign last_step = (step_reg == LAST_V);

    // result item
    always_comb begin
        res_o.parent_vertex = found_reg ? VERT_BITS'(min_par_reg) : '0;
        res_o.child_vertex  = found_reg ? VERT_BITS'(min_idx_reg) : '0;
        res_o.edge_weight   = found_reg ? WEIGHT_IN_BITS'(min_cost_reg) : '0;
        res_o.total_weight  = found_reg ? sum_sat : total_reg;
        res_o.last          = !found_reg || last_step;
        res_o.disconnected  = !found_reg;
    end

    // best-cost memory: read at the scan index, write back in the following cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            best_rd_reg <= best_mem[idx_reg];
        end
        if (wr_en) begin
            best_mem[s1_idx_reg] <= new_best;
        end
        s1_idx_reg <= idx_reg;
    end

    // run sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            s1_vld_reg  <= 1'b0;
            in_tree_reg <= '0;
            found_reg   <= 1'b0;
            total_reg   <= '0;
        end else begin
            s1_vld_reg <= rd_en;
            if (better) begin
                min_cost_reg <= new_best.cost;
                min_idx_reg  <= s1_idx_reg;
                min_par_reg  <= new_best.parent;
                found_reg    <= 1'b1;
            end
            case (state_reg)
                E_IDLE: begin
                    if (start_i) begin
                        found_reg <= 1'b0;
                        total_reg <= '0;
                        if (32'(start_vertex_i) < VERTICES) begin
                            state_reg    <= E_PASS;
                            cur_reg      <= VW'(start_vertex_i);
                            in_tree_reg  <= VERTICES'(1) << VW'(start_vertex_i);
                            idx_reg      <= '0;
                            step_reg     <= VW'(1);
                            first_reg    <= 1'b1;
                            min_cost_reg <= NO_EDGE;
                        end else begin
                            state_reg <= E_EMIT;
                        end
                    end
                end
                E_PASS: begin
                    if (idx_reg == LAST_V) begin
                        state_reg <= E_WAIT;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                E_WAIT: begin
                    state_reg <= E_EMIT;
                end
                E_EMIT: begin
                    if (res_ready_i) begin
                        if (!found_reg || last_step) begin
                            state_reg <= E_IDLE;
                        end else begin
                            state_reg    <= E_PASS;
                            total_reg    <= sum_sat;
                            in_tree_reg  <= in_tree_reg | (VERTICES'(1) << min_idx_reg);
                            cur_reg      <= min_idx_reg;
                            step_reg     <= step_reg + 1'b1;
                            idx_reg      <= '0;
                            first_reg    <= 1'b0;
                            min_cost_reg <= NO_EDGE;
                            found_reg    <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign busy_o       = (state_reg != E_IDLE);
    assign res_valid_o  = (state_reg == E_EMIT);
    assign mat_rd_en_o  = rd_en;
    assign mat_rd_row_o = cur_reg;
    assign mat_rd_col_o = idx_reg;

endmodule

[src/prim_minimum_spanning_tree.sv]
// Prim minimum spanning tree over an adjacency-matrix store: top level with stream ports.
// Instantiates pmst_matrix and pmst_engine; depends on pmst_pkg.
//
// Items on the slave side carry an opcode in s_tuser: insert an undirected edge, clear the
// graph, or run Prim's method from vertex_a. A run emits one result per tree edge in the
// order chosen (closest vertex first, lowest index on ties), with a running total that
// saturates at 16383; the final result has m_tlast set, and m_tuser flags a run that found
// no reachable vertex outside the tree. Each tree step is one scan over a matrix row and the
// best-cost memory, paced by the single read port of each memory; output stalls lengthen a run.
// An insert is two mirrored writes. After reset and after each clear item the matrix is swept
// one entry a cycle, during which s_tready is low.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree
    import pmst_pkg::*;
#(
    parameter int VERTICES    = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // vertex_a[2:0], vertex_b[5:3], weight[13:6], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // parent[2:0], child[5:3], edge_weight[13:6],
                                   // total_weight[27:14], zero pad
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // disconnected[0]
);

    localparam int VW = $clog2(VERTICES);

    logic                   accept;
    opcode_t                op;
    mat_cmd_t               mat_cmd;
    logic                   mat_busy;
    logic                   eng_busy;
    logic                   run_start;
    logic                   rd_en;
    logic [VW-1:0]          rd_row;
    logic [VW-1:0]          rd_col;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic                   res_valid;
    logic                   res_ready;
    result_t                res;
    logic                   m_tvalid_reg;
    result_t                out_reg;

    assign s_tready = !mat_busy && !eng_busy;
    assign accept   = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser);

    // item decode and dispatch
    always_comb begin
        mat_cmd.valid    = 1'b0;
        mat_cmd.op       = op;
        mat_cmd.vertex_a = s_tdata[2:0];
        mat_cmd.vertex_b = s_tdata[5:3];
        mat_cmd.weight   = s_tdata[13:6];
        run_start        = 1'b0;
        case (op)
            OP_INSERT: mat_cmd.valid = accept;
            OP_CLEAR:  mat_cmd.valid = accept;
            OP_RUN:    run_start     = accept;
            default:   run_start     = 1'b0;
        endcase
    end

    pmst_matrix #(
        .VERTICES    (VERTICES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (mat_cmd),
        .busy_o    (mat_busy),
        .rd_en_i   (rd_en),
        .rd_row_i  (rd_row),
        .rd_col_i  (rd_col),
        .rd_data_o (rd_data)
    );

    pmst_engine #(
        .VERTICES    (VERTICES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start_i        (run_start),
        .start_vertex_i (s_tdata[2:0]),
        .busy_o         (eng_busy),
        .mat_rd_en_o    (rd_en),
        .mat_rd_row_o   (rd_row),
        .mat_rd_col_o   (rd_col),
        .mat_rd_data_i  (rd_data),
        .res_valid_o    (res_valid),
        .res_ready_i    (res_ready),
        .res_o          (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_reg.total_weight, out_reg.edge_weight,
                       out_reg.child_vertex, out_reg.parent_vertex};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.disconnected;

endmodule

[bench/testbench.sv]
// Self-checking bench for prim_minimum_spanning_tree: graph edits and spanning tree runs.
// Holds its own Prim predictor in a scoreboard class; depends on pmst_pkg and the block RTL.
`timescale 1ns / 1ps

// tracks the graph the block should hold and the tree edges it should emit
class edge_scoreboard;
    localparam int NUM_VERTICES = 8;
    localparam logic [7:0] NO_EDGE = 8'hFF;

    logic [7:0] edge_cost [NUM_VERTICES][NUM_VERTICES];
    logic [7:0] reach_cost [NUM_VERTICES];
    logic [2:0] reach_parent [NUM_VERTICES];
    bit joined [NUM_VERTICES];
    pmst_pkg::result_t expected_edges [$];
    int mismatches;

    function new();
        mismatches = 0;
        wipe_graph();
    endfunction

    function void wipe_graph();
        foreach (edge_cost[i, j]) edge_cost[i][j] = NO_EDGE;
    endfunction

    // pull closer any outside vertex reachable from v
    function void relax_from(int v);
        for (int i = 0; i < NUM_VERTICES; i++) begin
            if (!joined[i] && edge_cost[v][i] < reach_cost[i]) begin
                reach_cost[i] = edge_cost[v][i];
                reach_parent[i] = 3'(v);
            end
        end
    endfunction

    function void push_edge(logic [2:0] par, logic [2:0] chi, logic [7:0] w,
                            logic [13:0] total, logic lst, logic dis);
        pmst_pkg::result_t r;
        r.parent_vertex = par;
        r.child_vertex  = chi;
        r.edge_weight   = w;
        r.total_weight  = total;
        r.last          = lst;
        r.disconnected  = dis;
        expected_edges.push_back(r);
    endfunction

    // grow the tree from start, closest vertex first, lowest index on ties
    function void grow_tree(logic [2:0] start);
        int unsigned sum;
        int pick;
        logic [7:0] best;
        bit found;
        for (int i = 0; i < NUM_VERTICES; i++) begin
            reach_cost[i] = NO_EDGE;
            reach_parent[i] = '0;
            joined[i] = 1'b0;
        end
        sum = 0;
        joined[start] = 1'b1;
        relax_from(int'(start));
        for (int round = 1; round < NUM_VERTICES; round++) begin
            best = NO_EDGE;
            found = 1'b0;
            pick = 0;
            for (int i = 0; i < NUM_VERTICES; i++) begin
                if (!joined[i] && reach_cost[i] < best) begin
                    best = reach_cost[i];
                    pick = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                push_edge('0, '0, '0, sum[13:0], 1'b1, 1'b1);
                return;
            end
            sum += reach_cost[pick];
            if (sum > pmst_pkg::TOTAL_MAX) sum = pmst_pkg::TOTAL_MAX;
            joined[pick] = 1'b1;
            push_edge(reach_parent[pick], pick[2:0], reach_cost[pick], sum[13:0],
                      round == NUM_VERTICES - 1, 1'b0);
            relax_from(pick);
        end
    endfunction

    function void note_item(logic [1:0] op, logic [2:0] a, logic [2:0] b, logic [7:0] w);
        case (op)
            pmst_pkg::OP_INSERT: begin
                edge_cost[a][b] = w;
                edge_cost[b][a] = w;
            end
            pmst_pkg::OP_RUN:   grow_tree(a);
            pmst_pkg::OP_CLEAR: wipe_graph();
            default: ;
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_edge(pmst_pkg::result_t got);
        pmst_pkg::result_t want;
        if (expected_edges.size() == 0) begin
            $error("result item with none expected: parent %0d child %0d weight %0d",
                   got.parent_vertex, got.child_vertex, got.edge_weight);
            mismatches++;
            return;
        end
        want = expected_edges.pop_front();
        compare_field("parent_vertex", 32'(want.parent_vertex), 32'(got.parent_vertex));
        compare_field("child_vertex", 32'(want.child_vertex), 32'(got.child_vertex));
        compare_field("edge_weight", 32'(want.edge_weight), 32'(got.edge_weight));
        compare_field("total_weight", 32'(want.total_weight), 32'(got.total_weight));
        compare_field("last", 32'(want.last), 32'(got.last));
        compare_field("disconnected", 32'(want.disconnected), 32'(got.disconnected));
    endfunction
endclass

module testbench;
    import pmst_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] NO_EDGE_W = 8'hFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    edge_scoreboard edge_board = new();
    result_t seen_edge;
    int burst_left = 0;
    int items_offered = 0;
    int cycle_count = 0;
    bit hold_off_req = 1'b0;

    prim_minimum_spanning_tree #(
        .VERTICES    (8),
        .WEIGHT_BITS (8)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // watch both channels for accepted items
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            edge_board.note_item(s_tuser, s_tdata[2:0], s_tdata[5:3], s_tdata[13:6]);
        if (aresetn && m_tvalid && m_tready) begin
            seen_edge.parent_vertex = m_tdata[2:0];
            seen_edge.child_vertex  = m_tdata[5:3];
            seen_edge.edge_weight   = m_tdata[13:6];
            seen_edge.total_weight  = m_tdata[27:14];
            seen_edge.last          = m_tlast;
            seen_edge.disconnected  = m_tuser[0];
            edge_board.check_edge(seen_edge);
        end
    end

    // receiver: stall patterns in spans, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 60);
                repeat (span) begin
                    @(posedge aclk);
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 3) != 0);
                        2: m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    // offer one item, in bursts separated by random gaps
    task automatic offer_item(logic [1:0] op, logic [2:0] a, logic [2:0] b, logic [7:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, w, b, a};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (op != OP_UNUSED) items_offered++;
    endtask

    // edge weight mix: full range, ties, zero and edge removal
    function automatic logic [7:0] random_weight();
        case ($urandom_range(0, 7))
            0: return NO_EDGE_W;
            1: return 8'd0;
            2, 3: return 8'($urandom_range(1, 4));
            default: return 8'($urandom_range(0, 254));
        endcase
    endfunction

    // main stimulus
    initial begin
        logic [2:0] order [8];
        logic [2:0] swap;
        int j;
        int chain_len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty graph, weight extremes, self loop, removal, ties, full tree
        offer_item(OP_RUN, 3'd0, 3'd7, 8'hFF);
        offer_item(OP_INSERT, 3'd0, 3'd7, 8'd0);
        offer_item(OP_INSERT, 3'd7, 3'd7, 8'd5);
        offer_item(OP_INSERT, 3'd1, 3'd2, 8'd254);
        offer_item(OP_INSERT, 3'd0, 3'd1, 8'd254);
        offer_item(OP_INSERT, 3'd3, 3'd4, NO_EDGE_W);
        offer_item(OP_UNUSED, 3'd7, 3'd7, 8'hFF);
        offer_item(OP_RUN, 3'd7, 3'd0, 8'd0);
        offer_item(OP_INSERT, 3'd2, 3'd3, 8'd10);
        offer_item(OP_INSERT, 3'd2, 3'd4, 8'd10);
        offer_item(OP_INSERT, 3'd2, 3'd5, 8'd10);
        offer_item(OP_INSERT, 3'd2, 3'd6, 8'd10);
        offer_item(OP_INSERT, 3'd6, 3'd0, 8'd1);
        offer_item(OP_INSERT, 3'd0, 3'd1, NO_EDGE_W);
        offer_item(OP_RUN, 3'd5, 3'd0, 8'd0);
        offer_item(OP_CLEAR, 3'd7, 3'd7, 8'hFF);
        offer_item(OP_RUN, 3'd3, 3'd0, 8'd0);
        offer_item(OP_INSERT, 3'd7, 3'd0, 8'd254);
        offer_item(OP_RUN, 3'd0, 3'd0, 8'd0);

        // random: mostly build a graph then run, with some noise
        items_offered = 0;
        hold_off_req = 1'b1;
        while (items_offered < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    offer_item(2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                               8'($urandom));
            end else begin
                if ($urandom_range(0, 2) == 0)
                    offer_item(OP_CLEAR, 3'($urandom), 3'($urandom), 8'($urandom));
                // random path through a shuffled vertex order
                if ($urandom_range(0, 1) == 1) begin
                    for (int i = 0; i < 8; i++) order[i] = 3'(i);
                    for (int i = 7; i > 0; i--) begin
                        j = $urandom_range(0, i);
                        swap = order[i];
                        order[i] = order[j];
                        order[j] = swap;
                    end
                    chain_len = $urandom_range(2, 8);
                    for (int i = 1; i < chain_len; i++)
                        offer_item(OP_INSERT, order[i-1], order[i],
                                   8'($urandom_range(0, 254)));
                end
                repeat ($urandom_range(0, 6))
                    offer_item(OP_INSERT, 3'($urandom), 3'($urandom), random_weight());
                repeat ($urandom_range(1, 2))
                    offer_item(OP_RUN, 3'($urandom), 3'($urandom), 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // let the monitor note the last item, drain results, then a margin for strays
        @(posedge aclk);
        while (edge_board.expected_edges.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (edge_board.mismatches == 0 && edge_board.expected_edges.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
